/* rtl/bsd_pkg.sv */
// Shared types, constants and the character classifier for the Base64 stream decoder.
package bsd_pkg;

   localparam int unsigned CHAR_W        = 8;
   localparam int unsigned SEXTET_W      = 6;
   localparam int unsigned BUF_W         = 3 * SEXTET_W;
   localparam int unsigned WORD_W        = 4 * SEXTET_W;
   localparam int unsigned QUEUE_DEPTH   = 4;

   localparam logic [CHAR_W-1:0] CHAR_UPPER_A = 8'h41;
   localparam logic [CHAR_W-1:0] CHAR_UPPER_Z = 8'h5a;
   localparam logic [CHAR_W-1:0] CHAR_LOWER_A = 8'h61;
   localparam logic [CHAR_W-1:0] CHAR_LOWER_Z = 8'h7a;
   localparam logic [CHAR_W-1:0] CHAR_DIGIT_0 = 8'h30;
   localparam logic [CHAR_W-1:0] CHAR_DIGIT_9 = 8'h39;
   localparam logic [CHAR_W-1:0] CHAR_PLUS    = 8'h2b;
   localparam logic [CHAR_W-1:0] CHAR_SLASH   = 8'h2f;

   localparam logic [SEXTET_W-1:0] LOWER_BASE = 6'd26;
   localparam logic [SEXTET_W-1:0] DIGIT_BASE = 6'd52;
   localparam logic [SEXTET_W-1:0] PLUS_CODE  = 6'd62;
   localparam logic [SEXTET_W-1:0] SLASH_CODE = 6'd63;

   // Index of the final byte of a job
   localparam logic [1:0] IDX_ONE   = 2'd0;
   localparam logic [1:0] IDX_TWO   = 2'd1;
   localparam logic [1:0] IDX_THREE = 2'd2;

   localparam logic [1:0] COUNT_TWO   = 2'd2;
   localparam logic [1:0] COUNT_THREE = 2'd3;

   typedef struct packed {
      logic                ok;
      logic [SEXTET_W-1:0] value;
   } sextet_type;

   // One unit of output work: one to three bytes, or a bare end marker
   typedef struct packed {
      logic [WORD_W-1:0] word;
      logic [1:0]        last_idx;
      logic              has_data;
      logic              msg_end;
   } job_type;

   function automatic sextet_type sextet_of(logic [CHAR_W-1:0] c);
      sextet_type r;
      begin
         r.ok    = 1'b1;
         r.value = '0;
         priority if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) begin
            r.value = SEXTET_W'(c - CHAR_UPPER_A);
         end else if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z) begin
            r.value = SEXTET_W'(c - CHAR_LOWER_A) + LOWER_BASE;
         end else if (c >= CHAR_DIGIT_0 && c <= CHAR_DIGIT_9) begin
            r.value = SEXTET_W'(c - CHAR_DIGIT_0) + DIGIT_BASE;
         end else if (c == CHAR_PLUS) begin
            r.value = PLUS_CODE;
         end else if (c == CHAR_SLASH) begin
            r.value = SLASH_CODE;
         end else begin
            r.ok = 1'b0;
         end
         return r;
      end
   endfunction

endpackage

/* rtl/bsd_front.sv */
// Front end: accepts characters, tracks the sextet group and emits byte jobs.
module bsd_front (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [bsd_pkg::CHAR_W-1:0]     req_char_code,
   input  logic                           req_message_last,
   input  logic                           queue_full,
   output logic                           push,
   output bsd_pkg::job_type               push_job
);

   logic [bsd_pkg::BUF_W-1:0] buf_ff, buf_in, buf_next;
   logic [1:0]                gc_ff, gc_in, gc_next;
   logic                      stopped_ff, stopped_in;

   bsd_pkg::sextet_type sx;
   logic accept, take, stop_now, full_group;

   assign req_ready = !queue_full;
   assign accept    = req_valid && req_ready;

   always_comb begin
      sx         = bsd_pkg::sextet_of(req_char_code);
      take       = !stopped_ff && sx.ok;
      stop_now   = !stopped_ff && !sx.ok;
      full_group = take && (gc_ff == bsd_pkg::COUNT_THREE);

      buf_next = buf_ff;
      gc_next  = gc_ff;
      if (full_group) begin
         buf_next = '0;
         gc_next  = '0;
      end else if (take) begin
         buf_next = {buf_ff[bsd_pkg::BUF_W-bsd_pkg::SEXTET_W-1:0], sx.value};
         gc_next  = gc_ff + 2'd1;
      end

      push_job.msg_end = req_message_last;
      priority if (full_group) begin
         push_job.word     = {buf_ff, sx.value};
         push_job.last_idx = bsd_pkg::IDX_THREE;
         push_job.has_data = 1'b1;
      end else if (gc_next == bsd_pkg::COUNT_THREE) begin
         // flush: left-align the pending sextets
         push_job.word     = {buf_next, {bsd_pkg::SEXTET_W{1'b0}}};
         push_job.last_idx = bsd_pkg::IDX_TWO;
         push_job.has_data = 1'b1;
      end else if (gc_next == bsd_pkg::COUNT_TWO) begin
         push_job.word     = {buf_next[2*bsd_pkg::SEXTET_W-1:0],
                              {(2*bsd_pkg::SEXTET_W){1'b0}}};
         push_job.last_idx = bsd_pkg::IDX_ONE;
         push_job.has_data = 1'b1;
      end else begin
         push_job.word     = '0;
         push_job.last_idx = bsd_pkg::IDX_ONE;
         push_job.has_data = 1'b0;
      end

      push = accept && (full_group || req_message_last);

      buf_in     = buf_ff;
      gc_in      = gc_ff;
      stopped_in = stopped_ff;
      if (accept) begin
         if (req_message_last) begin
            buf_in     = '0;
            gc_in      = '0;
            stopped_in = 1'b0;
         end else begin
            buf_in     = buf_next;
            gc_in      = gc_next;
            stopped_in = stopped_ff || stop_now;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         buf_ff     <= '0;
         gc_ff      <= '0;
         stopped_ff <= 1'b0;
      end else begin
         buf_ff     <= buf_in;
         gc_ff      <= gc_in;
         stopped_ff <= stopped_in;
      end
   end

endmodule

/* rtl/bsd_queue.sv */
// Short job queue between the front end and the byte serializer.
module bsd_queue #(
   parameter int unsigned DEPTH = bsd_pkg::QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  bsd_pkg::job_type push_job,
   output logic             full,
   input  logic             pop,
   output logic             empty,
   output bsd_pkg::job_type head
);

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_MAX = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(DEPTH);

   bsd_pkg::job_type  slot_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;

   assign full  = (count_ff == CNT_MAX);
   assign empty = (count_ff == '0);
   assign head  = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_MAX) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_MAX) ? '0 : rd_ptr_ff + 1'b1;
      end
      unique case ({push, pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

/* rtl/bsd_back.sv */
// Back end: walks the head job byte by byte onto the result channel.
module bsd_back (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       empty,
   input  bsd_pkg::job_type           head,
   output logic                       pop,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [bsd_pkg::CHAR_W-1:0] rsp_data_byte,
   output logic                       rsp_byte_valid,
   output logic                       rsp_run_last,
   output logic                       rsp_message_end
);

   logic [1:0] idx_ff, idx_in;
   logic       transfer;

   always_comb begin
      rsp_valid = !empty;
      unique case (idx_ff)
         bsd_pkg::IDX_ONE:   rsp_data_byte = head.word[23:16];
         bsd_pkg::IDX_TWO:   rsp_data_byte = head.word[15:8];
         default:            rsp_data_byte = head.word[7:0];
      endcase
      rsp_byte_valid  = head.has_data;
      rsp_run_last    = (idx_ff == head.last_idx);
      rsp_message_end = rsp_run_last && head.msg_end;

      transfer = rsp_valid && rsp_ready;
      // drop the job once its final byte is transferred
      pop    = transfer && rsp_run_last;
      idx_in = idx_ff;
      if (transfer) begin
         idx_in = rsp_run_last ? bsd_pkg::IDX_ONE : idx_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= bsd_pkg::IDX_ONE;
      end else begin
         idx_ff <= idx_in;
      end
   end

endmodule

/* rtl/base64_stream_decoder.sv */
// Top level of the Base64 stream decoder: front end, job queue and serializer.
//
//   channel  | ports                                   | direction
//   ---------+-----------------------------------------+----------
//   request  | req_valid/ready, char_code, message_last| in
//   response | rsp_valid/ready, data_byte, byte_valid, | out
//            | run_last, message_end                   |
//
// A character is taken in every cycle while the job queue has room; the front end
// decodes it in the same cycle and queues a job for a full group or a message end.
// The serializer sends one result per cycle while rsp_ready is high, and a full group
// yields three results; four characters per three bytes keeps the two sides matched.
// A response stall fills the QUEUE_DEPTH-entry job queue before req_ready drops.
// Reset (synchronous) clears the group state, the queue and the byte index.
module base64_stream_decoder #(
   parameter int unsigned QUEUE_DEPTH = bsd_pkg::QUEUE_DEPTH
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [bsd_pkg::CHAR_W-1:0] req_char_code,
   input  logic                       req_message_last,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [bsd_pkg::CHAR_W-1:0] rsp_data_byte,
   output logic                       rsp_byte_valid,
   output logic                       rsp_run_last,
   output logic                       rsp_message_end
);

   logic             queue_full, queue_empty, push, pop;
   bsd_pkg::job_type push_job, head;

   bsd_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_char_code    (req_char_code),
      .req_message_last (req_message_last),
      .queue_full       (queue_full),
      .push             (push),
      .push_job         (push_job)
   );

   bsd_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .full     (queue_full),
      .pop      (pop),
      .empty    (queue_empty),
      .head     (head)
   );

   bsd_back u_back (
      .clock           (clock),
      .reset           (reset),
      .empty           (queue_empty),
      .head            (head),
      .pop             (pop),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_data_byte   (rsp_data_byte),
      .rsp_byte_valid  (rsp_byte_valid),
      .rsp_run_last    (rsp_run_last),
      .rsp_message_end (rsp_message_end)
   );

endmodule

/* verif/tb_top.sv */
// Self-checking testbench for the Base64 stream decoder.
`timescale 1ns / 100ps

module tb_top;

   localparam int unsigned CHAR_W   = bsd_pkg::CHAR_W;
   localparam int unsigned SEXTET_W = bsd_pkg::SEXTET_W;

   localparam logic [CHAR_W-1:0] CHAR_PAD  = 8'h3d;
   localparam logic [CHAR_W-1:0] CHAR_NUL  = 8'h00;
   localparam logic [CHAR_W-1:0] CHAR_HIGH = 8'hff;
   localparam int IDLE_PCT     = 22;
   localparam int RANDOM_CHARS = 460;
   localparam int HOLD_CYCLES  = 120;
   localparam int TAIL_CYCLES  = 16;

   typedef struct packed {
      logic [CHAR_W-1:0] data_byte;
      logic              byte_valid;
      logic              run_last;
      logic              message_end;
   } decoded_type;

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_ready;
   logic [CHAR_W-1:0] req_char_code;
   logic              req_message_last;
   logic              rsp_valid;
   logic              rsp_ready;
   logic [CHAR_W-1:0] rsp_data_byte;
   logic              rsp_byte_valid;
   logic              rsp_run_last;
   logic              rsp_message_end;

   bit idle_on = 1'b1;
   int hold_left = 0;
   int chars_sent = 0;

   // Map a character to its sextet; returns 0 for anything outside the alphabet
   function automatic bit char_to_sextet(input logic [CHAR_W-1:0] ch,
                                         output logic [SEXTET_W-1:0] sx);
      sx = '0;
      if (ch >= bsd_pkg::CHAR_UPPER_A && ch <= bsd_pkg::CHAR_UPPER_Z)
         sx = SEXTET_W'(ch - bsd_pkg::CHAR_UPPER_A);
      else if (ch >= bsd_pkg::CHAR_LOWER_A && ch <= bsd_pkg::CHAR_LOWER_Z)
         sx = SEXTET_W'(ch - 8'd71);
      else if (ch >= bsd_pkg::CHAR_DIGIT_0 && ch <= bsd_pkg::CHAR_DIGIT_9)
         sx = SEXTET_W'(ch + 8'd4);
      else if (ch == bsd_pkg::CHAR_PLUS) sx = bsd_pkg::PLUS_CODE;
      else if (ch == bsd_pkg::CHAR_SLASH) sx = bsd_pkg::SLASH_CODE;
      else return 1'b0;
      return 1'b1;
   endfunction

   function automatic logic [CHAR_W-1:0] sextet_to_char(input int unsigned sx);
      if (sx < 26) return bsd_pkg::CHAR_UPPER_A + CHAR_W'(sx);
      if (sx < 52) return bsd_pkg::CHAR_LOWER_A + CHAR_W'(sx - 26);
      if (sx < 62) return bsd_pkg::CHAR_DIGIT_0 + CHAR_W'(sx - 52);
      if (sx == 62) return bsd_pkg::CHAR_PLUS;
      return bsd_pkg::CHAR_SLASH;
   endfunction

   class decode_scoreboard;
      logic [bsd_pkg::BUF_W-1:0] pend_sextets;
      logic [1:0]                pend_count;
      bit                        halted;
      decoded_type               bytes_due[$];
      int                        mismatches;

      function new();
         pend_sextets = '0;
         pend_count   = '0;
         halted       = 1'b0;
         mismatches   = 0;
      endfunction

      function void push_byte(ref decoded_type made[$], input logic [CHAR_W-1:0] b,
                              input bit valid);
         decoded_type r;
         r = '0;
         r.data_byte  = b;
         r.byte_valid = valid;
         made.push_back(r);
      endfunction

      // Advance the decoder state by one character and queue what it yields
      function void note_char(logic [CHAR_W-1:0] ch, logic last);
         decoded_type                made[$];
         logic [SEXTET_W-1:0]        sx;
         logic [bsd_pkg::WORD_W-1:0] word;
         if (!halted) begin
            if (!char_to_sextet(ch, sx)) begin
               halted = 1'b1;
            end else if (pend_count == bsd_pkg::COUNT_THREE) begin
               word = {pend_sextets, sx};
               push_byte(made, word[23:16], 1'b1);
               push_byte(made, word[15:8], 1'b1);
               push_byte(made, word[7:0], 1'b1);
               pend_sextets = '0;
               pend_count   = '0;
            end else begin
               pend_sextets = {pend_sextets[11:0], sx};
               pend_count   = pend_count + 2'd1;
            end
         end
         if (last) begin
            // left-align the partial group before cutting bytes
            if (pend_count == bsd_pkg::COUNT_TWO) word = {pend_sextets[11:0], 12'd0};
            else word = {pend_sextets, 6'd0};
            if (pend_count >= bsd_pkg::COUNT_TWO) push_byte(made, word[23:16], 1'b1);
            if (pend_count == bsd_pkg::COUNT_THREE) push_byte(made, word[15:8], 1'b1);
            if (made.size() == 0) push_byte(made, '0, 1'b0);
            made[made.size()-1].message_end = 1'b1;
            pend_sextets = '0;
            pend_count   = '0;
            halted       = 1'b0;
         end
         if (made.size() > 0) made[made.size()-1].run_last = 1'b1;
         foreach (made[i]) bytes_due.push_back(made[i]);
      endfunction

      function void report(string field, logic [CHAR_W-1:0] want, logic [CHAR_W-1:0] got);
         $display("%0t: %s expected %h actual %h", $time, field, want, got);
         mismatches++;
      endfunction

      function void check_byte(decoded_type got);
         decoded_type want;
         if (bytes_due.size() == 0) begin
            $display("%0t: unexpected result: expected none actual %h", $time, got);
            mismatches++;
            return;
         end
         want = bytes_due.pop_front();
         if (got.data_byte !== want.data_byte)
            report("data_byte", want.data_byte, got.data_byte);
         if (got.byte_valid !== want.byte_valid)
            report("byte_valid", want.byte_valid, got.byte_valid);
         if (got.run_last !== want.run_last)
            report("run_last", want.run_last, got.run_last);
         if (got.message_end !== want.message_end)
            report("message_end", want.message_end, got.message_end);
      endfunction
   endclass

   decode_scoreboard dec_sb = new();

   base64_stream_decoder u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_char_code    (req_char_code),
      .req_message_last (req_message_last),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_data_byte    (rsp_data_byte),
      .rsp_byte_valid   (rsp_byte_valid),
      .rsp_run_last     (rsp_run_last),
      .rsp_message_end  (rsp_message_end)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Note inputs before checking outputs so a same-edge result finds its expectation
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) dec_sb.note_char(req_char_code, req_message_last);
         if (rsp_valid && rsp_ready)
            dec_sb.check_byte({rsp_data_byte, rsp_byte_valid, rsp_run_last, rsp_message_end});
      end
   end

   // Receiver: random stalls, plus a counted hold-off on request
   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_left > 0) begin
            rsp_ready = 1'b0;
            hold_left--;
         end else begin
            rsp_ready = idle_on ? ($urandom_range(99) >= IDLE_PCT) : 1'b1;
         end
      end
   end

   task automatic send_char(input logic [CHAR_W-1:0] ch, input logic last);
      while (idle_on && $urandom_range(99) < IDLE_PCT) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid        = 1'b1;
      req_char_code    = ch;
      req_message_last = last;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
      req_valid = 1'b0;
   endtask

   // Send one message, flagging its final character
   task automatic send_msg(input logic [CHAR_W-1:0] msg[$]);
      foreach (msg[i]) begin
         chars_sent++;
         send_char(msg[i], i == msg.size() - 1);
      end
   endtask

   task automatic send_text(input string s);
      logic [CHAR_W-1:0] msg[$];
      for (int i = 0; i < s.len(); i++) msg.push_back(s[i]);
      send_msg(msg);
   endtask

   task automatic wait_drained();
      req_valid = 1'b0;
      while (dec_sb.bytes_due.size() != 0) @(posedge clock);
      @(negedge clock);
   endtask

   function automatic logic [CHAR_W-1:0] random_bad_char();
      logic [CHAR_W-1:0] ch;
      logic [SEXTET_W-1:0] sx;
      do ch = CHAR_W'($urandom_range(255)); while (char_to_sextet(ch, sx));
      return ch;
   endfunction

   task automatic send_random_msg();
      logic [CHAR_W-1:0] msg[$];
      int kind, len, pos;
      kind = $urandom_range(99);
      if (kind < 15) begin
         // noise: any byte at all
         len = $urandom_range(1, 8);
         repeat (len) msg.push_back(CHAR_W'($urandom_range(255)));
      end else begin
         len = $urandom_range(1, 12);
         repeat (len) msg.push_back(sextet_to_char($urandom_range(63)));
         if (len % 4 == 3 && $urandom_range(1)) msg.push_back(CHAR_PAD);
         if (len % 4 == 2 && $urandom_range(1)) begin
            msg.push_back(CHAR_PAD);
            msg.push_back(CHAR_PAD);
         end
         if (kind >= 85) begin
            pos = $urandom_range(msg.size());
            msg.insert(pos, random_bad_char());
         end
      end
      send_msg(msg);
   endtask

   initial begin
      bit hold_done, pause_done;
      hold_done  = 1'b0;
      pause_done = 1'b0;
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_char_code    = '0;
      req_message_last = 1'b0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // full group ending a message, lone sextet, one- and two-byte tails
      send_text("TWFu");
      send_text("Q");
      send_text("QQ");
      send_text("QUI");
      // pad as the only and last character
      send_text("=");
      // characters after the stop are ignored, the flush still emits
      send_text("QU=ZZ");
      send_msg('{bsd_pkg::CHAR_SLASH, bsd_pkg::CHAR_SLASH, CHAR_HIGH,
                 bsd_pkg::CHAR_UPPER_A});
      send_msg('{bsd_pkg::CHAR_PLUS, bsd_pkg::CHAR_DIGIT_0, bsd_pkg::CHAR_DIGIT_9,
                 bsd_pkg::CHAR_LOWER_Z, CHAR_NUL});
      wait_drained();

      chars_sent = 0;
      while (chars_sent < RANDOM_CHARS) begin
         if (!hold_done && chars_sent >= 150) begin
            hold_left = HOLD_CYCLES;
            hold_done = 1'b1;
         end
         if (!pause_done && chars_sent >= 330) begin
            wait_drained();
            pause_done = 1'b1;
         end
         idle_on = !(chars_sent >= 220 && chars_sent < 310);
         send_random_msg();
      end

      idle_on = 1'b0;
      wait_drained();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (dec_sb.mismatches == 0 && dec_sb.bytes_due.size() == 0)
         $display("base64_stream_decoder: match");
      else
         $display("base64_stream_decoder: mismatch");
      $finish;
   end

   initial begin
      #2000000;
      $display("base64_stream_decoder: mismatch");
      $finish;
   end

endmodule
